// ===== src/dq_pkg.sv =====
package dq_pkg;

   localparam int WORD_W = 32;
   localparam int MODE_W = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type POP_EMPTY_WORD = '1;

   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
   } cell_cmd_type;

endpackage

// ===== src/double_ended_queue.sv =====
// Channel   Ports                                   Direction  Flow control
// request   start, busy, req_mode, req_value        in         start while busy low
// response  rsp_valid, rsp_popped, rsp_status,      out        one-cycle strobe
//           rsp_occupancy
//
// Each beat is accepted at once and its response appears on the next cycle.
// Words live in a row of cells, front in cell zero; a front push or pop shifts
// the whole row by one cell, and a back push or pop works at the count boundary.
// Reset clears the count and the response strobe; cell contents stay undefined.
// The receiver cannot stall, so busy stays low and a beat may come every cycle.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [MODE_W-1:0]              req_mode,
   input  logic signed [WORD_W-1:0]       req_value,
   output logic                           rsp_valid,
   output logic signed [WORD_W-1:0]       rsp_popped,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   word_type         popped_ff;
   word_type         popped_in;
   status_type       status_ff;
   status_type       status_in;
   logic [CNT_W-1:0] occupancy_ff;

   cell_cmd_type     cmd;
   mode_type         mode;
   logic             accept;
   logic             full;
   logic             empty;
   word_type         push_word;
   word_type         back_word;
   word_type         cell_word [DEPTH];

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign mode = mode_type'(req_mode);
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign push_word = word_type'(req_value);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_word;
      word_type right_word;
      if (i == 0) begin : g_first
         assign left_word = push_word;
      end else begin : g_inner
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_mid
         assign right_word = cell_word[i+1];
      end
      dq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .push_word  (push_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | (cell_word[i] & {WORD_W{count_ff == CNT_W'(i + 1)}});
      end
   end

   always_comb begin
      cmd = '0;
      count_in = count_ff;
      status_in = STATUS_OK;
      popped_in = '0;
      if (accept) begin
         unique case (mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd.push_front = (mode == MODE_PUSH_FRONT);
                  cmd.push_back = (mode == MODE_PUSH_BACK);
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
                  popped_in = POP_EMPTY_WORD;
               end else begin
                  cmd.pop_front = (mode == MODE_POP_FRONT);
                  popped_in = (mode == MODE_POP_FRONT) ? cell_word[0] : back_word;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff <= popped_in;
      status_ff <= status_in;
      occupancy_ff <= count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_popped = signed'(popped_ff);
   assign rsp_status = status_ff;
   assign rsp_occupancy = occupancy_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Word count exceeds the depth.");

   a_beat_response: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("Accepted beat produced no response.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> occupancy_ff == CNT_W'(DEPTH))
      else $error("Full status reported below the depth.");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_EMPTY)
         |-> (occupancy_ff == '0 && popped_ff == POP_EMPTY_WORD))
      else $error("Empty status with held words or a wrong word.");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Push did not raise the count by one.");
`endif

endmodule

// ===== src/dq_cell.sv =====
module dq_cell
   import dq_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [CNT_W-1:0] count,
   input  word_type         push_word,
   input  word_type         left_word,
   input  word_type         right_word,
   output word_type         word
);

   word_type word_ff;
   word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (cmd.push_front) begin
         word_in = left_word;
      end else if (cmd.pop_front) begin
         word_in = right_word;
      end else if (cmd.push_back && (count == CNT_W'(INDEX))) begin
         word_in = push_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
